### src/itf_pkg.sv
// Integer text formatter: shared constants, ASCII codes, state type and the
// digit-to-character helper. No dependencies.
package itf_pkg;

   localparam int MAX_CHARS = 64;       // most characters emitted for one value
   localparam int DIG_N     = 11;       // most digits of a 32-bit value (octal)
   localparam int DIG_W     = $clog2(DIG_N);
   localparam int LEN_W     = $clog2(DIG_N + 1);
   localparam int POS_W     = 8;        // holds the longest layout (width, prec, prefix)

   localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
   localparam int          RECIP_SHFT = 35;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [1:0] RADIX_OCT = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;

   typedef enum logic [1:0] {
      BASE_8,
      BASE_10,
      BASE_16
   } base_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SUB,
      ST_SIZE,
      ST_BOUND,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'd0, d};
      end else begin
         c = CH_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

### src/integer_text_formatter_unit.sv
// Sequence: octal and hex produce one digit per step (up to 11 and 8 digits); decimal
//   uses a reciprocal-multiply step and a subtract step per digit (up to 10); then the
//   layout states ST_SIZE and ST_BOUND, then 1 char/cycle while the output is not stalled.
// A new item is taken once the last character sits in the output register.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// Depends on itf_pkg.
module integer_text_formatter_unit
   import itf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic        req_signed_mode,
   input  logic [1:0]  req_radix,
   input  logic [6:0]  req_field_width,
   input  logic        req_has_precision,
   input  logic [6:0]  req_precision,
   input  logic        req_zero_pad,
   input  logic        req_pad_right,
   input  logic        req_plus_sign,
   input  logic        req_space_sign,
   input  logic        req_alternate_form,
   // characters out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char
);

   // ---------------------------------------------------------------------
   // Sequencer state and per-item registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [31:0]      mag_ff, mag_in;          // remaining magnitude
   logic [63:0]      prod_ff, prod_in;        // reciprocal product for /10
   base_type         base_ff, base_in;
   logic [LEN_W-1:0] len_ff, len_in;          // digits produced so far
   logic [3:0]       digit_ff [DIG_N];        // digit values, least significant first
   logic             dig_we;
   logic [3:0]       dig_val;

   logic [1:0]       plen_ff, plen_in;        // sign/prefix length: 0, 1 or 2
   logic [7:0]       pfx0_ff, pfx0_in;        // first prefix char (sign or '0')
   logic             hasp_ff, hasp_in;
   logic [6:0]       prec_ff, prec_in;
   logic [6:0]       width_ff, width_in;
   logic             left_ff, left_in;
   logic             zmode_ff, zmode_in;      // zero padding in effect

   logic [6:0]       ndig_ff, ndig_in;        // digits incl. precision zeros
   logic [POS_W-1:0] pad_ff, pad_in;
   logic [POS_W-1:0] emit_n_ff, emit_n_in;    // characters to emit after truncation

   // layout boundaries: spaces | prefix | zeros | digits | spaces
   logic [POS_W-1:0] s1_ff, s1_in;
   logic [POS_W-1:0] s2_ff, s2_in;
   logic [POS_W-1:0] s3_ff, s3_in;
   logic [POS_W-1:0] s4_ff, s4_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------
   logic             req_take;
   logic             out_free;
   logic             emit_go;
   logic             neg;
   logic [7:0]       sign_ch;
   logic             has_sign;
   base_type         base_sel;

   logic [28:0]      quot;
   logic [31:0]      quot32;
   logic [31:0]      rem32;
   logic [31:0]      mag_shift;

   logic [6:0]       len7;
   logic [6:0]       ndig_c;
   logic [POS_W-1:0] total_c;
   logic [POS_W-1:0] width8;
   logic [POS_W-1:0] chars_c;
   logic [POS_W-1:0] zeros_c;

   logic [POS_W-1:0] off;
   logic [DIG_W-1:0] rd_idx;
   logic [7:0]       emit_ch;
   logic             emit_last;

   assign req_take = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_go  = (state_ff == ST_EMIT) && out_free;

   // sign and base selection at item entry
   assign neg      = req_signed_mode && req_value[31];
   assign has_sign = req_signed_mode && (neg || req_plus_sign || req_space_sign);

   always_comb begin
      if (neg) begin
         sign_ch = CH_MINUS;
      end else if (req_plus_sign) begin
         sign_ch = CH_PLUS;
      end else begin
         sign_ch = CH_SPACE;
      end
   end

   always_comb begin
      if (req_signed_mode || req_radix == RADIX_DEC) begin
         base_sel = BASE_10;
      end else if (req_radix == RADIX_OCT) begin
         base_sel = BASE_8;
      end else begin
         base_sel = BASE_16;
      end
   end

   // divide-by-ten finish: q = prod >> 35, r = mag - 10q
   assign quot      = prod_ff[63:RECIP_SHFT];
   assign quot32    = {3'd0, quot};
   assign rem32     = mag_ff - ((quot32 << 3) + (quot32 << 1));
   assign mag_shift = (base_ff == BASE_16) ? (mag_ff >> 4) : (mag_ff >> 3);

   // sizing
   assign len7    = 7'(len_ff);
   assign ndig_c  = (hasp_ff && prec_ff > len7) ? prec_ff : len7;
   assign total_c = {1'b0, ndig_c} + {6'd0, plen_ff};
   assign width8  = {1'b0, width_ff};
   assign chars_c = (width8 > total_c) ? width8 : total_c;
   assign zeros_c = {1'b0, ndig_ff - len7} + (zmode_ff ? pad_ff : '0);

   // character selection by position
   assign off    = pos_ff - s3_ff;
   assign rd_idx = DIG_W'(len_ff - LEN_W'(1) - off[LEN_W-1:0]);

   always_comb begin
      if (pos_ff < s1_ff) begin
         emit_ch = CH_SPACE;
      end else if (pos_ff < s2_ff) begin
         emit_ch = (pos_ff == s1_ff) ? pfx0_ff : CH_X;
      end else if (pos_ff < s3_ff) begin
         emit_ch = CH_ZERO;
      end else if (pos_ff < s4_ff) begin
         emit_ch = digit_char(digit_ff[rd_idx]);
      end else begin
         emit_ch = CH_SPACE;
      end
   end

   assign emit_last = (pos_ff == emit_n_ff - POS_W'(1));

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (base_ff == BASE_10) begin
               state_in = ST_SUB;
            end else if (mag_shift == 32'd0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SUB: begin
            state_in = (quot == 29'd0) ? ST_SIZE : ST_STEP;
         end
         ST_SIZE: begin
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------------
   always_comb begin
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      len_in       = len_ff;
      plen_in      = plen_ff;
      pfx0_in      = pfx0_ff;
      hasp_in      = hasp_ff;
      prec_in      = prec_ff;
      width_in     = width_ff;
      left_in      = left_ff;
      zmode_in     = zmode_ff;
      ndig_in      = ndig_ff;
      pad_in       = pad_ff;
      emit_n_in    = emit_n_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      s3_in        = s3_ff;
      s4_in        = s4_ff;
      pos_in       = pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dig_we       = 1'b0;
      dig_val      = 4'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mag_in   = neg ? (32'd0 - req_value) : req_value;
               base_in  = base_sel;
               len_in   = '0;
               hasp_in  = req_has_precision;
               prec_in  = req_precision;
               width_in = req_field_width;
               left_in  = req_pad_right;
               zmode_in = req_zero_pad && !req_has_precision && !req_pad_right;
               pfx0_in  = has_sign ? sign_ch : CH_ZERO;
               if (has_sign) begin
                  plen_in = 2'd1;
               end else if (!req_signed_mode && req_alternate_form &&
                            req_value != 32'd0 && base_sel == BASE_16) begin
                  plen_in = 2'd2;
               end else if (!req_signed_mode && req_alternate_form &&
                            req_value != 32'd0 && base_sel == BASE_8) begin
                  plen_in = 2'd1;
               end else begin
                  plen_in = 2'd0;
               end
            end
         end
         ST_STEP: begin
            if (base_ff == BASE_10) begin
               prod_in = mag_ff * RECIP_10;
            end else begin
               dig_val = (base_ff == BASE_16) ? mag_ff[3:0] : {1'b0, mag_ff[2:0]};
               dig_we  = 1'b1;
               mag_in  = mag_shift;
               len_in  = len_ff + LEN_W'(1);
            end
         end
         ST_SUB: begin
            dig_val = rem32[3:0];
            dig_we  = 1'b1;
            mag_in  = quot32;
            len_in  = len_ff + LEN_W'(1);
         end
         ST_SIZE: begin
            ndig_in   = ndig_c;
            pad_in    = (width8 > total_c) ? (width8 - total_c) : '0;
            emit_n_in = (int'(chars_c) > MAX_CHARS) ? POS_W'(MAX_CHARS) : chars_c;
         end
         ST_BOUND: begin
            s1_in  = (!left_ff && !zmode_ff) ? pad_ff : '0;
            s2_in  = s1_in + {6'd0, plen_ff};
            s3_in  = s2_in + zeros_c;
            s4_in  = s3_in + {{(POS_W - LEN_W){1'b0}}, len_ff};
            pos_in = '0;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = emit_ch;
               rsp_last_in  = emit_last;
               pos_in       = pos_ff + POS_W'(1);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      base_ff     <= base_in;
      len_ff      <= len_in;
      plen_ff     <= plen_in;
      pfx0_ff     <= pfx0_in;
      hasp_ff     <= hasp_in;
      prec_ff     <= prec_in;
      width_ff    <= width_in;
      left_ff     <= left_in;
      zmode_ff    <= zmode_in;
      ndig_ff     <= ndig_in;
      pad_ff      <= pad_in;
      emit_n_ff   <= emit_n_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      s4_ff       <= s4_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (dig_we) begin
         digit_ff[DIG_W'(len_ff)] <= dig_val;
      end
   end

   // ports
   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // reciprocal divide always leaves a decimal remainder
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB) |-> (rem32 < 32'd10))
      else $error("divide step remainder out of range");

   // digit store never overflows
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_SUB) |-> (len_ff < LEN_W'(DIG_N)))
      else $error("digit count overflow");

   // emission position stays inside the truncated length
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pos_ff < emit_n_ff))
      else $error("emit position past end");

   // a taken item always starts a fresh digit run
   a_take_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_STEP && len_ff == '0))
      else $error("item not started correctly");

endmodule
